### hw/rtl/rrts_pkg.sv
package rrts_pkg;

  // Number of tasks, task 0 being the idle task
  localparam int TASK_COUNT = 5;
  localparam int IDX_W      = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  // Field widths of the stream payloads
  localparam int DATA_W     = 32;
  localparam int TASK_W     = 3;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 2'd0,
    OP_DELAY     = 2'd1,
    OP_SWITCH    = 2'd2,
    OP_SET_STACK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LOAD
  } state_t;

  // Command word that walks the row of task cells, one cell per cycle.
  // data: new tick count, wake time or stack pointer depending on op.
  // hi/lo: first ready task above / at-or-below the running task.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [DATA_W-1:0] data;
    idx_t              tgt;
    logic              tgt_ok;
    idx_t              cur;
    logic              hi_ok;
    idx_t              hi;
    logic              lo_ok;
    idx_t              lo;
  } cmd_t;

endpackage

### hw/rtl/rrts_cell.sv
module rrts_cell import rrts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  idx_t              cell_id,
  input  cmd_t              cmd_in,
  output cmd_t              cmd_out,
  output logic [DATA_W-1:0] stack_out
);

  logic              ready_r, ready_nxt;
  logic [DATA_W-1:0] wake_r, wake_nxt;
  logic [DATA_W-1:0] stack_r, stack_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              hit;
  logic              cand;

  // Act on the passing request for this task, then hand it on
  always_comb begin
    ready_nxt = ready_r;
    wake_nxt  = wake_r;
    stack_nxt = stack_r;
    cmd_nxt   = cmd_in;
    hit       = cmd_in.tgt_ok && (cmd_in.tgt == cell_id);
    cand      = (cell_id != '0) && ready_r;
    if (cmd_in.valid) begin
      unique case (cmd_in.op)
        OP_TICK: begin
          // wake a blocked task whose time has come
          if ((cell_id != '0) && !ready_r && (wake_r == cmd_in.data)) begin
            ready_nxt = 1'b1;
          end
        end
        OP_DELAY: begin
          if (hit) begin
            wake_nxt  = cmd_in.data;
            ready_nxt = 1'b0;
          end
        end
        OP_SWITCH: begin
          if (hit) begin
            stack_nxt = cmd_in.data;
          end
          // record first ready candidate on each side of the running task
          if (cand) begin
            if ((cell_id > cmd_in.cur) && !cmd_in.hi_ok) begin
              cmd_nxt.hi_ok = 1'b1;
              cmd_nxt.hi    = cell_id;
            end else if ((cell_id <= cmd_in.cur) && !cmd_in.lo_ok) begin
              cmd_nxt.lo_ok = 1'b1;
              cmd_nxt.lo    = cell_id;
            end
          end
        end
        OP_SET_STACK: begin
          if (hit) begin
            stack_nxt = cmd_in.data;
          end
        end
        default: begin
          ready_nxt = ready_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b1;
      cmd_r   <= '0;
    end else begin
      ready_r <= ready_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wake_r  <= wake_nxt;
    stack_r <= stack_nxt;
  end

  assign cmd_out   = cmd_r;
  assign stack_out = stack_r;

endmodule

### hw/rtl/round_robin_task_scheduler_top.sv
// Channel   Direction  Payload
// in_*      request    tuser: op; tdata: delay_ticks, stack_value, task_index
// out_*     result     tdata: running_task_out, stack_out, switch_request
//
// One request at a time: after acceptance the request walks the row of task
// cells, the new running task is taken from the end of the row, and the stack
// word is read into the output register in the load state. The next request
// can be taken in the cycle after the load.
// Reset (rst_n low, synchronous) clears the tick count, makes task 1 running
// and marks every task ready; no request is taken while reset is held.
// A stalled result holds in the output register; the next request may be
// accepted meanwhile and waits before its load.
module round_robin_task_scheduler_top import rrts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] delay_ticks, [63:32] stack_value, [66:64] task_index, rest zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] running_task_out, [34:3] stack_out, [35] switch_request, rest zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  state_t                state_r, state_nxt;
  logic [DATA_W-1:0]     tick_r, tick_nxt;
  idx_t                  cur_r, cur_nxt;
  logic                  req_r, req_nxt;
  cmd_t                  head_r, head_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  accept;
  logic                  load_out;
  op_t                   op_in;
  logic [DATA_W-1:0]     delay_in;
  logic [DATA_W-1:0]     sp_in;
  logic [TASK_W-1:0]     idx_in;
  cmd_t                  chain [TASK_COUNT+1];
  logic [DATA_W-1:0]     stack_w [TASK_COUNT];
  cmd_t                  tail;

  assign op_in    = op_t'(in_tuser);
  assign delay_in = in_tdata[31:0];
  assign sp_in    = in_tdata[63:32];
  assign idx_in   = in_tdata[66:64];
  assign accept   = in_tvalid && in_tready;
  assign tail     = chain[TASK_COUNT];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (tail.valid) state_nxt = ST_LOAD;
      ST_LOAD: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = rst_n;
      ST_RUN:  in_tready = 1'b0;
      ST_LOAD: load_out  = !out_valid_r || out_tready;
      default: in_tready = 1'b0;
    endcase
  end

  // Build the request word for the cell row and advance scheduler state
  always_comb begin
    head_nxt = '0;
    tick_nxt = tick_r;
    cur_nxt  = cur_r;
    req_nxt  = req_r;
    if (accept) begin
      head_nxt.valid = 1'b1;
      head_nxt.op    = op_in;
      head_nxt.cur   = cur_r;
      unique case (op_in)
        OP_TICK: begin
          tick_nxt      = tick_r + 32'd1;
          head_nxt.data = tick_r + 32'd1;
          req_nxt       = 1'b1;
        end
        OP_DELAY: begin
          // the idle task cannot be blocked
          head_nxt.data   = tick_r + delay_in;
          head_nxt.tgt    = cur_r;
          head_nxt.tgt_ok = (cur_r != '0);
          req_nxt         = (cur_r != '0);
        end
        OP_SWITCH: begin
          head_nxt.data   = sp_in;
          head_nxt.tgt    = cur_r;
          head_nxt.tgt_ok = 1'b1;
          req_nxt         = 1'b0;
        end
        OP_SET_STACK: begin
          head_nxt.data   = sp_in;
          head_nxt.tgt    = idx_t'(idx_in);
          head_nxt.tgt_ok = ({{(DATA_W-TASK_W){1'b0}}, idx_in} < DATA_W'(TASK_COUNT));
          req_nxt         = 1'b0;
        end
        default: begin
          req_nxt = 1'b0;
        end
      endcase
    end
    // pick next ready task round robin, idle task if none
    if ((state_r == ST_RUN) && tail.valid && (tail.op == OP_SWITCH)) begin
      if (tail.hi_ok) begin
        cur_nxt = tail.hi;
      end else if (tail.lo_ok) begin
        cur_nxt = tail.lo;
      end else begin
        cur_nxt = '0;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{(OUT_DATA_W-TASK_W-DATA_W-1){1'b0}}, req_r, stack_w[cur_r],
                       TASK_W'(cur_r)};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      cur_r       <= idx_t'(1);
      req_r       <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      cur_r       <= cur_nxt;
      req_r       <= req_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Row of task cells, the request moving one cell per cycle
  assign chain[0] = head_r;

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    rrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_id   (idx_t'(i)),
      .cmd_in    (chain[i]),
      .cmd_out   (chain[i+1]),
      .stack_out (stack_w[i])
    );
  end

endmodule

### tb/sched_dispatch_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own picture of the kernel state and
// compares every result with the dispatch predicted for the matching request.
module sched_dispatch_checker import rrts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    errors,
  output int                    awaited,
  output int                    checked,
  output int                    idle_runs,
  output int                    wakeups
);

  typedef struct packed {
    logic [TASK_W-1:0] run_id;
    logic [DATA_W-1:0] sp;
    logic              req;
  } dispatch_t;

  // Shadow kernel state
  logic [DATA_W-1:0] ticks;
  int                running;
  logic              ready     [TASK_COUNT];
  logic [DATA_W-1:0] wake_at   [TASK_COUNT];
  logic [DATA_W-1:0] stack_ptr [TASK_COUNT];

  dispatch_t awaited_dispatch[$];
  int        fail_count;
  int        checked_count;
  int        idle_count;
  int        wake_count;

  assign errors    = fail_count;
  assign checked   = checked_count;
  assign idle_runs = idle_count;
  assign wakeups   = wake_count;

  initial begin
    fail_count    = 0;
    checked_count = 0;
    idle_count    = 0;
    wake_count    = 0;
  end

  // Apply one request to the shadow state and return the dispatch it yields
  task automatic advance_kernel(input op_t op, input logic [DATA_W-1:0] dly,
                                input logic [DATA_W-1:0] sp, input logic [TASK_W-1:0] idx,
                                output dispatch_t d);
    int   cur;
    int   cand;
    int   next;
    logic req;
    cur  = running;
    req  = 1'b0;
    next = 0;
    case (op)
      OP_TICK: begin
        ticks = ticks + 1;
        for (int i = 1; i < TASK_COUNT; i++) begin
          if (!ready[i] && wake_at[i] == ticks) begin
            ready[i] = 1'b1;
            wake_count++;
          end
        end
        req = 1'b1;
      end
      OP_DELAY: begin
        // the idle task cannot be blocked
        if (cur != 0) begin
          wake_at[cur] = ticks + dly;
          ready[cur]   = 1'b0;
          req          = 1'b1;
        end
      end
      OP_SWITCH: begin
        stack_ptr[cur] = sp;
        // scan upwards from the running task, skip idle, running task last
        for (int k = TASK_COUNT; k >= 1; k--) begin
          cand = (cur + k) % TASK_COUNT;
          if (cand != 0 && ready[cand]) next = cand;
        end
        cur = next;
        if (cur == 0) idle_count++;
      end
      default: begin
        if (int'(idx) < TASK_COUNT) stack_ptr[idx] = sp;
      end
    endcase
    running  = cur;
    d.run_id = cur[TASK_W-1:0];
    d.sp     = stack_ptr[cur];
    d.req    = req;
  endtask

  // Compare one result with the oldest dispatch still awaited
  task automatic check_dispatch(input logic [OUT_DATA_W-1:0] word);
    dispatch_t want;
    if (awaited_dispatch.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, actual %h", $time, word[35:0]);
    end else begin
      want = awaited_dispatch.pop_front();
      checked_count++;
      if (word[2:0] !== want.run_id) begin
        fail_count++;
        $display("%0t: running_task_out expected %0d actual %0d",
                 $time, want.run_id, word[2:0]);
      end
      if (word[34:3] !== want.sp) begin
        fail_count++;
        $display("%0t: stack_out expected %h actual %h", $time, want.sp, word[34:3]);
      end
      if (word[35] !== want.req) begin
        fail_count++;
        $display("%0t: switch_request expected %b actual %b", $time, want.req, word[35]);
      end
    end
  endtask

  // Results first: a result taken at an edge never belongs to the request taken there
  always @(posedge clk) begin
    dispatch_t fresh;
    if (!rst_n) begin
      ticks   = '0;
      running = 1;
      for (int i = 0; i < TASK_COUNT; i++) begin
        ready[i]     = 1'b1;
        wake_at[i]   = '0;
        stack_ptr[i] = '0;
      end
      awaited_dispatch.delete();
    end else begin
      if (out_tvalid && out_tready) check_dispatch(out_tdata);
      if (in_tvalid && in_tready) begin
        advance_kernel(op_t'(in_tuser), in_tdata[31:0], in_tdata[63:32], in_tdata[66:64],
                       fresh);
        awaited_dispatch.push_back(fresh);
      end
    end
    awaited <= awaited_dispatch.size();
  end

endmodule

### tb/round_robin_task_scheduler_top_test.sv
`timescale 1ns / 1ps

module round_robin_task_scheduler_top_test import rrts_pkg::*;;

  localparam int RANDOM_REQUESTS = 1850;
  localparam int CYCLE_LIMIT     = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = OP_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int errors;
  int awaited;
  int checked;
  int idle_runs;
  int wakeups;

  int   sent = 0;
  int   cycles = 0;
  int   sink_gap;
  int   stall_left = 0;
  logic calm_src = 1'b0;
  logic calm_sink = 1'b0;

  round_robin_task_scheduler_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sched_dispatch_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .awaited    (awaited),
    .checked    (checked),
    .idle_runs  (idle_runs),
    .wakeups    (wakeups)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold out_tready low for a random number of cycles after each taken result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (out_tvalid && out_tready) begin
      sink_gap = calm_sink ? 0 : $urandom_range(0, 12);
      stall_left <= sink_gap;
      out_tready <= (sink_gap == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_tready <= 1'b1;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("round_robin_task_scheduler_top_test: done, errors");
      $finish;
    end
  end

  // Present one request after a random gap and wait until it is taken
  task automatic post_request(input op_t op, input logic [31:0] dly,
                              input logic [31:0] sp, input logic [2:0] idx);
    int gap;
    gap = calm_src ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, idx, sp, dly};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // Stop sending until every result in flight has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Mostly ticks, short delays and switches so blocked tasks keep waking up
  task automatic random_request();
    int          pick;
    op_t         op;
    logic [31:0] dly;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_TICK;
    else if (pick < 55) op = OP_DELAY;
    else if (pick < 85) op = OP_SWITCH;
    else op = OP_SET_STACK;
    dly = $urandom_range(1, 10);
    if ($urandom_range(0, 19) == 0) dly = $urandom_range(11, 40);
    post_request(op, dly, $urandom(), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Load every stack word first, task 1 before anything reads it
    post_request(OP_SET_STACK, 32'h0, 32'h2000_1000, 3'd1);
    post_request(OP_SET_STACK, 32'h0, 32'h0000_0000, 3'd0);
    post_request(OP_SET_STACK, 32'h0, 32'hFFFF_FFFF, 3'd2);
    post_request(OP_SET_STACK, 32'h0, $urandom(), 3'd3);
    post_request(OP_SET_STACK, 32'h0, $urandom(), 3'd4);
    // index out of range: ignored
    post_request(OP_SET_STACK, 32'h0, 32'hDEAD_BEEF, 3'd7);
    post_request(OP_SET_STACK, 32'h0, 32'h1234_5678, 3'd5);
    post_request(OP_TICK, $urandom(), $urandom(), 3'd0);
    post_request(OP_SWITCH, 32'h0, 32'h2000_0F00, 3'd0);
    post_request(OP_DELAY, 32'd3, 32'h0, 3'd0);
    post_request(OP_SWITCH, 32'h0, 32'h2000_2F00, 3'd0);
    post_request(OP_DELAY, 32'd1, 32'h0, 3'd0);
    post_request(OP_SWITCH, 32'h0, 32'h2000_3F00, 3'd0);
    // zero delay leaves task 4 blocked until the count wraps round
    post_request(OP_DELAY, 32'd0, 32'h0, 3'd0);
    post_request(OP_SWITCH, 32'h0, 32'h2000_4F00, 3'd0);
    post_request(OP_DELAY, 32'd2, 32'h0, 3'd0);
    // every task blocked: the idle task runs and ignores delays
    post_request(OP_SWITCH, 32'h0, 32'h2000_0E00, 3'd0);
    post_request(OP_DELAY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    post_request(OP_DELAY, 32'd0, 32'h0, 3'd0);
    post_request(OP_SWITCH, 32'h2000_0D00, 32'h2000_0D00, 3'd0);
    // ticks wake tasks 3, 1 and 2 in turn
    post_request(OP_TICK, 32'h0, 32'h0, 3'd0);
    post_request(OP_SWITCH, 32'h0, 32'h2000_0C00, 3'd0);
    post_request(OP_TICK, 32'h0, 32'h0, 3'd0);
    post_request(OP_TICK, 32'h0, 32'h0, 3'd0);
    post_request(OP_SWITCH, 32'h0, 32'h2000_3E00, 3'd0);
    drain_results();

    // Random traffic in segments, some of them without idling on one side
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 150 == 0) begin
        calm_src  = ($urandom_range(0, 3) == 0);
        calm_sink = ($urandom_range(0, 3) == 0);
      end
      if (n % 300 == 299) drain_results();
      random_request();
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d switches to idle, %0d wake-ups",
             sent, checked, idle_runs, wakeups);
    if (errors == 0 && awaited == 0) begin
      $display("round_robin_task_scheduler_top_test: done, clean");
    end else begin
      $display("round_robin_task_scheduler_top_test: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_cell.sv
hw/rtl/round_robin_task_scheduler_top.sv
tb/sched_dispatch_checker.sv
tb/round_robin_task_scheduler_top_test.sv
